/* hw/rtl/rhsv_pkg.sv */
// rhsv_pkg: widths, hue constants and the front-end result struct for the
// rgb to hsv pixel core; no dependencies, compiled first
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int CH_W   = 8;              // channel byte width
  localparam int HUE_W  = 15;             // hue width, 1/64 degree units
  localparam int DIV_QW = HUE_W;          // quotient bits, one per divider stage
  localparam int DIV_DW = CH_W;           // divisor width
  localparam int NUM_W  = DIV_QW + DIV_DW; // dividend width

  // hue constants in 1/64 degree units
  localparam int HUE_UNITS_60  = 3840;
  localparam int HUE_UNITS_120 = 7680;
  localparam int HUE_UNITS_240 = 15360;
  localparam int HUE_UNITS_360 = 23040;

  // dividends, divisors and side data handed from the front end to the dividers
  typedef struct packed {
    logic [NUM_W-1:0]  num_h;
    logic [DIV_DW-1:0] den_h;
    logic              hue_ok;
    logic [NUM_W-1:0]  num_s;
    logic [DIV_DW-1:0] den_s;
    logic [CH_W-1:0]   mx;
  } front_t;

endpackage

/* hw/rtl/rhsv_pix_if.sv */
// rhsv_pix_if: valid/ready channel carrying one rgb pixel request
// depends on rhsv_pkg
`timescale 1ns / 1ps

interface rhsv_pix_if import rhsv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hw/rtl/rhsv_hsv_if.sv */
// rhsv_hsv_if: valid/ready channel carrying one hsv result request
// depends on rhsv_pkg
`timescale 1ns / 1ps

interface rhsv_hsv_if import rhsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  brightness;
  logic             hue_valid;

  modport source (output valid, output hue, output saturation, output brightness,
                  output hue_valid, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input hue_valid, output ready);
endinterface

/* hw/rtl/rhsv_front.sv */
// rhsv_front: two register stages that find max/min, the hue sector and
// build the hue and saturation dividends; depends on rhsv_pkg
`timescale 1ns / 1ps

module rhsv_front import rhsv_pkg::*; (
  input  logic            clk,
  input  logic [1:0]      en,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  output front_t          res
);

  // hue sector codes
  localparam logic [1:0] SEC_RED_POS = 2'd0;
  localparam logic [1:0] SEC_RED_NEG = 2'd1;
  localparam logic [1:0] SEC_GREEN   = 2'd2;
  localparam logic [1:0] SEC_BLUE    = 2'd3;

  logic [CH_W-1:0] mx_c, mn_c;
  logic [1:0]      sec_c;
  logic signed [CH_W:0] diff_c;

  logic [CH_W-1:0] s1_mx;
  logic [CH_W-1:0] s1_d;
  logic [1:0]      s1_sec;
  logic signed [CH_W:0] s1_diff;

  logic [HUE_W-1:0]        off_units;
  logic signed [NUM_W:0]   base;
  logic signed [NUM_W:0]   term;
  logic signed [NUM_W:0]   sum_h;
  logic                    grey;

  // max, min and sector, ties go red then green then blue
  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c) mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
    if (mx_c == red) begin
      sec_c  = (green >= blue) ? SEC_RED_POS : SEC_RED_NEG;
      diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (mx_c == green) begin
      sec_c  = SEC_GREEN;
      diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_c  = SEC_BLUE;
      diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_mx   <= mx_c;
      s1_d    <= mx_c - mn_c;
      s1_sec  <= sec_c;
      s1_diff <= diff_c;
    end
  end

  // sector offset in hue units
  always_comb begin
    unique case (s1_sec)
      SEC_RED_POS: off_units = '0;
      SEC_RED_NEG: off_units = HUE_W'(HUE_UNITS_360);
      SEC_GREEN:   off_units = HUE_W'(HUE_UNITS_120);
      SEC_BLUE:    off_units = HUE_W'(HUE_UNITS_240);
      default:     off_units = '0;
    endcase
  end

  // hue dividend: offset*d + 60deg*diff, never negative
  always_comb begin
    grey  = (s1_d == '0);
    base  = $signed((NUM_W+1)'(off_units) * (NUM_W+1)'(s1_d));
    term  = (NUM_W+1)'(s1_diff) * $signed((NUM_W+1)'(HUE_UNITS_60));
    sum_h = base + term;
  end

  // stage 2 register, grey hue and black saturation divide zero by one
  always_ff @(posedge clk) begin
    if (en[1]) begin
      res.num_h  <= grey ? '0 : sum_h[NUM_W-1:0];
      res.den_h  <= grey ? DIV_DW'(1) : s1_d;
      res.hue_ok <= !grey;
      res.num_s  <= (NUM_W'(s1_d) << CH_W) - NUM_W'(s1_d);
      res.den_s  <= (s1_mx == '0) ? DIV_DW'(1) : s1_mx;
      res.mx     <= s1_mx;
    end
  end

endmodule

/* hw/rtl/rhsv_div.sv */
// rhsv_div: pipelined restoring divider, one quotient bit per register
// stage, with side data carried alongside; depends on rhsv_pkg
`timescale 1ns / 1ps

module rhsv_div import rhsv_pkg::*; #(
  parameter int QW = DIV_QW,
  parameter int DW = DIV_DW,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic [QW-1:0]    en,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  input  logic [SW-1:0]    side,
  output logic [QW-1:0]    quo,
  output logic [SW-1:0]    side_out
);

  localparam int NW = QW + DW;

  // working word: remainder on top, unused dividend bits, quotient bits below
  logic [NW-1:0] w     [QW];
  logic [DW-1:0] den_r [QW];
  logic [SW-1:0] side_r[QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] w_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   rem;
    logic          ge;

    if (i == 0) begin : g_first
      assign w_in    = num;
      assign den_in  = den;
      assign side_in = side;
    end else begin : g_next
      assign w_in    = w[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    // one restoring step
    always_comb begin
      trial = w_in[NW-1:QW-1];
      ge    = (trial >= {1'b0, den_in});
      rem   = ge ? (trial - {1'b0, den_in}) : trial;
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        w[i]      <= {rem[DW-1:0], w_in[QW-2:0], ge};
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign quo      = w[QW-1][QW-1:0];
  assign side_out = side_r[QW-1];

endmodule

/* hw/rtl/rgb_to_hsv_pixel_core.sv */
// rgb_to_hsv_pixel_core: streaming rgb to hsv converter, top level
// depends on rhsv_pkg, rhsv_pix_if, rhsv_hsv_if, rhsv_front, rhsv_div
//
// Usage:
//   pix is a valid/ready sink taking one 8-bit rgb pixel per request; hsv is
//   a valid/ready source giving hue (1/64 degree), saturation (255 = 1.0),
//   brightness (largest channel) and hue_valid (cleared for grey pixels,
//   whose hue reads 0).
//   The datapath is 17 register stages: two front stages (max/min, sector,
//   dividends) and 15 divider stages that each resolve one quotient bit for
//   hue and saturation in parallel. An accepted pixel moves through the
//   front stages and then the divider stages in order. One pixel per clock
//   is sustained while the receiver keeps ready high.
//   Each stage has its own valid bit and loads when it is empty or the stage
//   after it moves, so a stalled receiver holds the result in the last stage
//   while empty stages upstream still fill; pix.ready drops only once every
//   stage holds a pixel. Nothing is dropped or repeated across stalls.
//   Synchronous reset clears all valid bits; the block takes pixels in the
//   first cycle after reset.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_core import rhsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rhsv_pix_if.sink    pix,
  rhsv_hsv_if.source  hsv
);

  localparam int NSTG = 2 + DIV_QW;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;
  front_t          fr;
  logic [HUE_W-1:0]  hue_q;
  logic [DIV_QW-1:0] sat_q;
  logic              hue_ok;
  logic [CH_W-1:0]   mx_out;

  // stage enables: a stage loads when some stage at or after it has room
  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = hsv.ready || !(&v[NSTG-1:i]);
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pix.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // max/min, sector and dividends
  rhsv_front u_front (
    .clk   (clk),
    .en    (en[1:0]),
    .red   (pix.red),
    .green (pix.green),
    .blue  (pix.blue),
    .res   (fr)
  );

  // hue divider, carries the hue valid flag
  rhsv_div #(.QW(DIV_QW), .DW(DIV_DW), .SW(1)) u_div_hue (
    .clk      (clk),
    .en       (en[NSTG-1:2]),
    .num      (fr.num_h),
    .den      (fr.den_h),
    .side     (fr.hue_ok),
    .quo      (hue_q),
    .side_out (hue_ok)
  );

  // saturation divider, carries the brightness
  rhsv_div #(.QW(DIV_QW), .DW(DIV_DW), .SW(CH_W)) u_div_sat (
    .clk      (clk),
    .en       (en[NSTG-1:2]),
    .num      (fr.num_s),
    .den      (fr.den_s),
    .side     (fr.mx),
    .quo      (sat_q),
    .side_out (mx_out)
  );

  // ports
  assign pix.ready      = en[0];
  assign hsv.valid      = v[NSTG-1];
  assign hsv.hue        = hue_q;
  assign hsv.saturation = sat_q[CH_W-1:0];
  assign hsv.brightness = mx_out;
  assign hsv.hue_valid  = hue_ok;

  // grey results carry zero hue and zero saturation
  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && !hsv.hue_valid |-> hsv.hue == '0 && hsv.saturation == '0)
    else $error("grey result with nonzero hue or saturation");

  // hue stays below 360 degrees
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> hsv.hue < HUE_W'(HUE_UNITS_360))
    else $error("hue out of range");

  // a colored pixel always has some saturation
  a_sat_nonzero: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && hsv.hue_valid |-> hsv.saturation != '0)
    else $error("colored result with zero saturation");

  // input backpressure only when the whole pipeline is full and stalled
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pix.ready |-> (&v) && !hsv.ready)
    else $error("input stalled with room in the pipeline");

endmodule
